// ----- rtl/core/timed_intensity_fader_unit_assert.svh -----
// Assertion macros shared by the timed intensity fader modules.
`ifndef TIMED_INTENSITY_FADER_UNIT_ASSERT_SVH
`define TIMED_INTENSITY_FADER_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define TIF_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A consequence that must hold in the clock cycle after its cause.
`define TIF_CHECK_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

// ----- rtl/core/tif_pkg.sv -----
// Shared types, codes and widths of the timed intensity fader.
package tif_pkg;

	localparam int NUM_CHANNELS_DEF = 6;

	localparam int CH_W    = 3;
	localparam int MODE_W  = 2;
	localparam int LEVEL_W = 16;
	localparam int DUR_W   = 32;
	localparam int EL_W    = 32;
	localparam int TIME_W  = 64;
	localparam int PROD_W  = LEVEL_W + EL_W;
	localparam int DIV_STEPS = LEVEL_W;
	localparam int DCNT_W  = $clog2(DIV_STEPS);

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 24;

	localparam logic OP_CTRL = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CH_W-1:0] CH_ALL = '0;

	typedef enum logic [MODE_W-1:0] {
		MODE_TEMP   = 2'd0,
		MODE_PERM   = 2'd1,
		MODE_CANCEL = 2'd2,
		MODE_NONE   = 2'd3
	} tif_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DECIDE,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_FINISH,
		ST_EMIT
	} tif_state_t;

	typedef struct packed {
		logic apply_ctrl;
		logic start_tick;
		logic load_ch;
		logic mul;
		logic div_init;
		logic div_step;
		logic finish;
		logic out_load;
	} tif_cmd_t;

	typedef struct packed {
		logic fade;
		logic div_done;
		logic last_ch;
		logic any;
		logic out_free;
	} tif_sts_t;

endpackage

// ----- rtl/core/timed_intensity_fader_unit.sv -----
// Top level of the timed intensity fader: stream ports, controller and datapath.
// A control beat (tuser low) is applied as it is taken, and the next beat can follow at once. A tick
// beat (tuser high) walks the channels one after another: a channel that fades passes through
// load, decide, multiply, divider init, the 16 steps of the shared bit-serial divider and finish,
// while an inactive or expiring channel passes only through load, decide and finish.
// When any channel is still active afterwards, one report beat per channel follows, one per
// cycle while the output is taken, the last one marked by tlast. The next beat is taken only
// after the walk and its report beats, so a report beat held back by the output delays it; the
// final report beat may still wait in the output register at that point.
`include "timed_intensity_fader_unit_assert.svh"

module timed_intensity_fader_unit #(
	parameter int NUM_CHANNELS = tif_pkg::NUM_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// channel [2:0], mode [4:3], level [20:5], duration_us [52:21], tick_us [84:53], zeros
	input  logic [tif_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// op: low for a control command, high for a time tick
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_channel [2:0], out_level [18:3], zeros
	output logic [tif_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                              m_axis_tlast
);
	import tif_pkg::*;

	localparam int MODE_LO  = CH_W;
	localparam int LEVEL_LO = MODE_LO + MODE_W;
	localparam int DUR_LO   = LEVEL_LO + LEVEL_W;
	localparam int EL_LO    = DUR_LO + DUR_W;

	tif_cmd_t           cmd;
	tif_sts_t           sts;
	logic [CH_W-1:0]    out_channel;
	logic [LEVEL_W-1:0] out_level;

	tif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.op       (s_axis_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	tif_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.channel     (s_axis_tdata[MODE_LO-1:0]),
		.mode        (s_axis_tdata[LEVEL_LO-1:MODE_LO]),
		.level       (s_axis_tdata[DUR_LO-1:LEVEL_LO]),
		.duration_us (s_axis_tdata[EL_LO-1:DUR_LO]),
		.tick_us     (s_axis_tdata[EL_LO+EL_W-1:EL_LO]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_channel (out_channel),
		.out_level   (out_level),
		.last        (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_DATA_W'({out_level, out_channel});

endmodule

// ----- rtl/core/tif_ctrl.sv -----
// Sequencing state machine of the timed intensity fader.
`include "timed_intensity_fader_unit_assert.svh"

module tif_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            op,
	input  tif_pkg::tif_sts_t sts,
	output tif_pkg::tif_cmd_t cmd
);
	import tif_pkg::*;

	tif_state_t state_q;
	tif_state_t state_d;
	logic       accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_TICK) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD:   state_d = ST_DECIDE;
			ST_DECIDE: state_d = sts.fade ? ST_MUL : ST_FINISH;
			ST_MUL:    state_d = ST_DINIT;
			ST_DINIT:  state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!sts.last_ch) begin
					state_d = ST_LOAD;
				end else if (sts.any || sts.fade) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (sts.out_free && sts.last_ch) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.apply_ctrl = accept && op == OP_CTRL;
				cmd.start_tick = accept && op == OP_TICK;
			end
			ST_LOAD:   cmd.load_ch  = 1'b1;
			ST_DECIDE: ;
			ST_MUL:    cmd.mul      = 1'b1;
			ST_DINIT:  cmd.div_init = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_FINISH: cmd.finish   = 1'b1;
			ST_EMIT:   cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	`TIF_CHECK(a_emit_needs_active, (state_q == ST_EMIT) |-> sts.any, "report without an active channel")
	`TIF_CHECK(a_div_only_on_fade, (state_q == ST_DIV) |-> sts.fade, "division on a channel that does not fade")
	`TIF_CHECK_NEXT(a_emit_holds, state_q == ST_EMIT && !sts.out_free, state_q == ST_EMIT, "report state left while stalled")

endmodule

// ----- rtl/core/tif_dp.sv -----
// Channel store, multiplier, bit-serial divider and output register of the fader.
`include "timed_intensity_fader_unit_assert.svh"

module tif_dp #(
	parameter int NUM_CHANNELS = tif_pkg::NUM_CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tif_pkg::tif_cmd_t            cmd,
	output tif_pkg::tif_sts_t            sts,
	input  logic [tif_pkg::CH_W-1:0]     channel,
	input  logic [tif_pkg::MODE_W-1:0]   mode,
	input  logic [tif_pkg::LEVEL_W-1:0]  level,
	input  logic [tif_pkg::DUR_W-1:0]    duration_us,
	input  logic [tif_pkg::EL_W-1:0]     tick_us,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tif_pkg::CH_W-1:0]     out_channel,
	output logic [tif_pkg::LEVEL_W-1:0]  out_level,
	output logic                         last
);
	import tif_pkg::*;

	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [TIME_W-1:0]  time_q  [NUM_CHANNELS];
	logic [LEVEL_W-1:0] level_q [NUM_CHANNELS];

	logic [CW-1:0]      ch_q;
	logic [EL_W-1:0]    el_q;
	logic [TIME_W-1:0]  t_q;
	logic [LEVEL_W-1:0] lv_q;
	logic [PROD_W-1:0]  x_q;
	logic [TIME_W-1:0]  rem_q;
	logic [LEVEL_W-1:0] qx_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic               any_q;
	logic               out_valid_q;
	logic [CH_W-1:0]    out_channel_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic               last_q;

	logic               ch_ok;
	logic [CW-1:0]      wr_idx;
	logic               fade;
	logic               last_ch;
	logic [TIME_W-1:0]  t_new;
	logic [TIME_W:0]    rs;
	logic [TIME_W:0]    diff;
	logic               ge;
	logic [TIME_W-1:0]  rem_d;
	logic               rup;
	logic [LEVEL_W:0]   r;
	logic [LEVEL_W-1:0] lv_new;

	assign ch_ok   = channel != CH_ALL && 32'(channel) <= 32'(NUM_CHANNELS);
	assign wr_idx  = CW'(channel - CH_W'(1));
	assign fade    = t_q > TIME_W'(el_q);
	assign last_ch = ch_q == CW'(NUM_CHANNELS - 1);
	assign t_new   = t_q - TIME_W'(el_q);

	// One restoring step: the next dividend bit is shifted in from the top of qx_q.
	assign rs    = {rem_q, qx_q[LEVEL_W-1]};
	assign diff  = rs - {1'b0, t_q};
	assign ge    = rs >= {1'b0, t_q};
	assign rem_d = ge ? diff[TIME_W-1:0] : rs[TIME_W-1:0];

	// Round to nearest with ties down: add one only when twice the remainder exceeds the divisor.
	assign rup    = {rem_q, 1'b0} > {1'b0, t_q};
	assign r      = {1'b0, qx_q} + (LEVEL_W+1)'(rup);
	assign lv_new = lv_q - r[LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				time_q[i]  <= '0;
				level_q[i] <= '0;
			end
		end else if (cmd.apply_ctrl) begin
			if (channel == CH_ALL) begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					time_q[i]  <= '0;
					level_q[i] <= '0;
				end
			end else if (ch_ok) begin
				unique case (tif_mode_t'(mode))
					MODE_TEMP: begin
						time_q[wr_idx]  <= TIME_W'(duration_us);
						level_q[wr_idx] <= level;
					end
					MODE_PERM: begin
						time_q[wr_idx]  <= '1;
						level_q[wr_idx] <= level;
					end
					MODE_CANCEL: begin
						time_q[wr_idx]  <= '0;
						level_q[wr_idx] <= '0;
					end
					default: ;
				endcase
			end
		end else if (cmd.finish) begin
			if (fade) begin
				time_q[ch_q]  <= t_new;
				level_q[ch_q] <= lv_new;
			end else if (t_q != '0) begin
				time_q[ch_q]  <= '0;
				level_q[ch_q] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= '0;
			any_q  <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.start_tick) begin
				ch_q  <= '0;
				any_q <= 1'b0;
			end else if (cmd.finish || cmd.out_load) begin
				ch_q <= last_ch ? '0 : ch_q + CW'(1);
			end
			if (cmd.finish && fade) begin
				any_q <= 1'b1;
			end
			if (cmd.div_init) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_tick) begin
			el_q <= tick_us;
		end
		if (cmd.load_ch) begin
			t_q  <= time_q[ch_q];
			lv_q <= level_q[ch_q];
		end
		if (cmd.mul) begin
			x_q <= PROD_W'(lv_q) * PROD_W'(el_q);
		end
		if (cmd.div_init) begin
			rem_q <= TIME_W'(x_q[PROD_W-1:LEVEL_W]);
			qx_q  <= x_q[LEVEL_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= rem_d;
			qx_q  <= {qx_q[LEVEL_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_channel_q <= CH_W'(ch_q) + CH_W'(1);
			out_level_q   <= level_q[ch_q];
			last_q        <= last_ch;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign out_level   = out_level_q;
	assign last        = last_q;

	assign sts.fade     = fade;
	assign sts.div_done = dcnt_q == DCNT_W'(DIV_STEPS - 1);
	assign sts.last_ch  = last_ch;
	assign sts.any      = any_q;
	assign sts.out_free = !out_valid_q || out_ready;

	`TIF_CHECK(a_out_no_overwrite, cmd.out_load |-> (!out_valid_q || out_ready), "waiting beat overwritten")
	`TIF_CHECK(a_rem_below_divisor, cmd.div_step |-> (rem_q < t_q), "partial remainder not below divisor")
	`TIF_CHECK_NEXT(a_tick_restarts, cmd.start_tick, !any_q && ch_q == '0, "tick did not restart the channel walk")

endmodule
